// ----- sv/sampled_data_delay_align_checker_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the sampled data delay align checker
// Clocked on clk, disabled while rst is high.
// ---------------------------------------------------------------------------
`ifndef SAMPLED_DATA_DELAY_ALIGN_CHECKER_MACROS_SVH
`define SAMPLED_DATA_DELAY_ALIGN_CHECKER_MACROS_SVH

// same-cycle implication
`define SDAC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sdac assertion failed");

// next-cycle implication
`define SDAC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sdac assertion failed");

`endif

// ----- sv/sdac_pkg.sv -----
// ---------------------------------------------------------------------------
// sdac_pkg
// Shared types and constants of the sampled data delay align checker.
// ---------------------------------------------------------------------------
`default_nettype none

package sdac_pkg;

  localparam int IN_SAMPLES_DEF  = 32;
  localparam int OUT_SAMPLES_DEF = 64;
  localparam int DELAY_W         = 6;

  typedef struct packed {
    logic in_clock;
    logic in_bit;
    logic out_clock;
    logic out_bit;
    logic locked;
  } in_item_t;

  typedef struct packed {
    logic [DELAY_W-1:0] delay;
    logic               synchronized;
    logic               error_seen;
    logic               align_found;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic out_edge;
    logic step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic start_search;
    logic hit;
    logic last;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

// ----- sv/sdac_in_if.sv -----
// ---------------------------------------------------------------------------
// sdac_in_if
// Valid/ready channel carrying one sampled tick.
// ---------------------------------------------------------------------------
`default_nettype none

interface sdac_in_if import sdac_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- sv/sdac_out_if.sv -----
// ---------------------------------------------------------------------------
// sdac_out_if
// Valid/ready channel carrying one checker result.
// ---------------------------------------------------------------------------
`default_nettype none

interface sdac_out_if import sdac_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- sv/sdac_ctrl.sv -----
// ---------------------------------------------------------------------------
// sdac_ctrl
// Sequencer: accept tick, handle output edge, walk search, retire result.
// ---------------------------------------------------------------------------
`default_nettype none

module sdac_ctrl import sdac_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    item_valid,
  output logic         item_ready,
  input  wire status_t status,
  output cmd_t         cmd
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_EDGE   = 2'd1;
  localparam logic [1:0] S_SEARCH = 2'd2;
  localparam logic [1:0] S_FINISH = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  assign item_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (item_valid) begin
          cmd.load   = 1'b1;
          state_next = S_EDGE;
        end
      end
      S_EDGE: begin
        cmd.out_edge = 1'b1;
        state_next   = status.start_search ? S_SEARCH : S_FINISH;
      end
      S_SEARCH: begin
        cmd.step = 1'b1;
        if (status.hit || status.last) state_next = S_FINISH;
      end
      S_FINISH: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

endmodule

`default_nettype wire

// ----- sv/sdac_datapath.sv -----
// ---------------------------------------------------------------------------
// sdac_datapath
// Sample windows, edge counter, sync check, offset search and result register.
// ---------------------------------------------------------------------------
`default_nettype none

module sdac_datapath import sdac_pkg::*; #(
  parameter int IN_SAMPLES  = IN_SAMPLES_DEF,
  parameter int OUT_SAMPLES = OUT_SAMPLES_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire cmd_t     cmd,
  output status_t       status,
  input  wire in_item_t item_data,
  output logic          result_valid,
  input  wire logic     result_ready,
  output out_item_t     result_data
);

  localparam bit HAS_SEARCH = (OUT_SAMPLES > IN_SAMPLES);
  localparam int SPAN       = HAS_SEARCH ? OUT_SAMPLES - IN_SAMPLES : 1;
  localparam int OFF_W      = $clog2(OUT_SAMPLES);
  localparam int CNT_W      = $clog2(OUT_SAMPLES + 2);
  localparam int IDX_W      = $clog2(IN_SAMPLES);
  localparam int CMP_W      = $clog2(IN_SAMPLES + OUT_SAMPLES + 1);
  localparam int SCAN_W     = HAS_SEARCH ? OUT_SAMPLES : IN_SAMPLES;

  in_item_t               itm;
  logic [IN_SAMPLES-1:0]  in_win;
  logic [OUT_SAMPLES-1:0] out_win;
  logic [OUT_SAMPLES-1:0] out_win_shift;
  logic                   prev_in;
  logic                   prev_out;
  logic [CNT_W-1:0]       cnt;
  logic [CNT_W-1:0]       cnt_inc;
  logic [OFF_W-1:0]       delay_reg;
  logic                   sync;
  logic                   err;
  logic                   align;
  logic [SCAN_W-1:0]      scan;
  logic [OFF_W-1:0]       off;
  logic                   out_fall;
  logic                   in_fall;
  logic                   check;
  logic                   in_range;
  logic [IDX_W-1:0]       idx;
  logic                   sync_ok;

  assign out_fall      = prev_out & ~itm.out_clock;
  assign in_fall       = prev_in & ~itm.in_clock;
  assign out_win_shift = {itm.out_bit, out_win[OUT_SAMPLES-1:1]};
  assign cnt_inc       = (cnt <= CNT_W'(OUT_SAMPLES)) ? cnt + CNT_W'(1) : cnt;
  assign check         = out_fall && (cnt_inc > CNT_W'(OUT_SAMPLES)) && itm.locked;

  // newest output bit against input window tap IN_SAMPLES-1-delay
  assign in_range = (CMP_W'(delay_reg) < CMP_W'(IN_SAMPLES));
  assign idx      = IDX_W'(CMP_W'(IN_SAMPLES - 1) - CMP_W'(delay_reg));
  assign sync_ok  = in_range && (itm.out_bit == in_win[idx]);

  assign status.start_search = check && !sync && HAS_SEARCH;
  assign status.hit          = (scan[IN_SAMPLES-1:0] == in_win);
  assign status.last         = (off == OFF_W'(SPAN - 1));
  assign status.out_free     = !result_valid || result_ready;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      itm <= item_data;
    end
    if (cmd.out_edge) begin
      scan <= SCAN_W'(out_win_shift);
      off  <= '0;
    end else if (cmd.step) begin
      scan <= scan >> 1;
      off  <= off + OFF_W'(1);
    end
    if (cmd.finish) begin
      result_data.delay        <= DELAY_W'(delay_reg);
      result_data.synchronized <= sync;
      result_data.error_seen   <= err;
      result_data.align_found  <= align;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_win       <= '0;
      out_win      <= '0;
      prev_in      <= 1'b0;
      prev_out     <= 1'b0;
      cnt          <= '0;
      delay_reg    <= '0;
      sync         <= 1'b0;
      err          <= 1'b0;
      align        <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (cmd.load) begin
        err   <= 1'b0;
        align <= 1'b0;
      end
      if (cmd.out_edge && out_fall) begin
        out_win <= out_win_shift;
        cnt     <= cnt_inc;
        if (check && sync && !sync_ok) begin
          sync <= 1'b0;
          err  <= 1'b1;
        end
      end
      if (cmd.step && status.hit) begin
        delay_reg <= off;
        sync      <= 1'b1;
        align     <= 1'b1;
      end
      if (cmd.finish) begin
        if (in_fall) in_win <= {itm.in_bit, in_win[IN_SAMPLES-1:1]};
        prev_in      <= itm.in_clock;
        prev_out     <= itm.out_clock;
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ----- sv/sampled_data_delay_align_checker.sv -----
// ---------------------------------------------------------------------------
// sampled_data_delay_align_checker
// Bit error checker that finds and tracks the delay between sampled streams.
//
//   channel  dir  payload
//   item     in   in_clock, in_bit, out_clock, out_bit, locked
//   result   out  delay[5:0], synchronized, error_seen, align_found
//
// One tick at a time: accept, output edge, search, retire.
// Without a search the search state is skipped; a search walks one offset per cycle,
// up to OUT_SAMPLES-IN_SAMPLES offsets, and stops early on a hit.
// Retire waits while the result register holds an untaken transfer.
// Synchronous reset clears windows, counter, delay and sync; no clear pass.
// ---------------------------------------------------------------------------
`default_nettype none

module sampled_data_delay_align_checker import sdac_pkg::*; #(
  parameter int IN_SAMPLES  = IN_SAMPLES_DEF,
  parameter int OUT_SAMPLES = OUT_SAMPLES_DEF
) (
  input wire logic  clk,
  input wire logic  rst,
  sdac_in_if.sink   item,
  sdac_out_if.source result
);

  cmd_t    cmd;
  status_t status;

  sdac_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item.valid),
    .item_ready (item.ready),
    .status     (status),
    .cmd        (cmd)
  );

  sdac_datapath #(
    .IN_SAMPLES  (IN_SAMPLES),
    .OUT_SAMPLES (OUT_SAMPLES)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .item_data    (item.data),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .result_data  (result.data)
  );

endmodule

`default_nettype wire

// ----- sv/sdac_checker.sv -----
// ---------------------------------------------------------------------------
// sdac_checker
// Port-level checks of the delay align checker, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none
`include "sampled_data_delay_align_checker_macros.svh"

module sdac_checker import sdac_pkg::*; (
  input wire logic      clk,
  input wire logic      rst,
  input wire logic      item_valid,
  input wire logic      item_ready,
  input wire logic      result_valid,
  input wire logic      result_ready,
  input wire out_item_t result_data
);

  `SDAC_ASSERT_NOW(a_flags_exclusive, result_valid, !(result_data.error_seen && result_data.align_found))
  `SDAC_ASSERT_NOW(a_align_syncs, result_valid && result_data.align_found, result_data.synchronized)
  `SDAC_ASSERT_NOW(a_error_unsyncs, result_valid && result_data.error_seen, !result_data.synchronized)
  `SDAC_ASSERT_NEXT(a_one_tick_in_flight, item_valid && item_ready, !item_ready)
  `SDAC_ASSERT_NEXT(a_result_holds, result_valid && !result_ready, result_valid && $stable(result_data))

endmodule

bind sampled_data_delay_align_checker sdac_checker u_sdac_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item.valid),
  .item_ready   (item.ready),
  .result_valid (result.valid),
  .result_ready (result.ready),
  .result_data  (result.data)
);

`default_nettype wire

// ----- dv/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Feeds sampled clock/data ticks to the delay align checker and compares
// every result transfer with an in-bench model of both sample windows, the
// offset search and the synchronized bit check. Ticks come from streams of
// periodic bit patterns with a chosen lead, bit errors, lock drops and clock
// skew, plus pure noise, with random gaps and stalls and one long output hold.
// ----------------------------------------------------------------------------

module testbench;
  import sdac_pkg::*;

  localparam int IN_N         = IN_SAMPLES_DEF;
  localparam int OUT_N        = OUT_SAMPLES_DEF;
  localparam int SPAN         = OUT_N - IN_N;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = SPAN + 8;
  localparam int TICK_W       = $bits(in_item_t);

  logic clk;
  logic rst;

  sdac_in_if  item_if ();
  sdac_out_if result_if ();

  sampled_data_delay_align_checker DUT (
    .clk    (clk),
    .rst    (rst),
    .item   (item_if),
    .result (result_if)
  );

  // model state
  logic [IN_N-1:0]  in_win       = '0;
  logic [OUT_N-1:0] out_win      = '0;
  logic             prev_in_clk  = 1'b0;
  logic             prev_out_clk = 1'b0;
  int               out_edges    = 0;
  int               delay_r      = 0;
  logic             sync_r       = 1'b0;
  out_item_t        align_results_q[$];

  int errors       = 0;
  int ticks_sent   = 0;
  int aligns_found = 0;
  int sync_losses  = 0;
  bit quiet        = 1'b0;
  bit hold_pending = 1'b0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic void step_align_checker(in_item_t t);
    out_item_t r;
    logic      hit;
    r   = '0;
    hit = 1'b0;
    if (prev_out_clk && !t.out_clock) begin
      out_win = {t.out_bit, out_win[OUT_N-1:1]};
      if (out_edges <= OUT_N) out_edges++;
      if (out_edges > OUT_N && t.locked) begin
        if (!sync_r) begin
          for (int i = 0; i < SPAN; i++) begin
            if (!hit && out_win[i +: IN_N] == in_win) begin
              hit           = 1'b1;
              delay_r       = i;
              sync_r        = 1'b1;
              r.align_found = 1'b1;
            end
          end
        end else if (delay_r >= IN_N || out_win[OUT_N-1] != in_win[IN_N-1-delay_r]) begin
          sync_r       = 1'b0;
          r.error_seen = 1'b1;
        end
      end
    end
    if (prev_in_clk && !t.in_clock) in_win = {t.in_bit, in_win[IN_N-1:1]};
    prev_in_clk    = t.in_clock;
    prev_out_clk   = t.out_clock;
    r.delay        = DELAY_W'(delay_r);
    r.synchronized = sync_r;
    aligns_found  += r.align_found;
    sync_losses   += r.error_seen;
    align_results_q.push_back(r);
  endfunction

  function automatic in_item_t random_tick();
    logic [TICK_W-1:0] raw;
    raw = TICK_W'($urandom);
    return raw;
  endfunction

  task automatic report_mismatch(string what);
    errors++;
    if (errors <= 50) $display("tb: mismatch at %0t: %s", $time, what);
  endtask

  task automatic send_tick(in_item_t t);
    while (!quiet && $urandom_range(99) < 15) begin
      item_if.valid <= 1'b0;
      item_if.data  <= random_tick();
      @(posedge clk);
    end
    item_if.valid <= 1'b1;
    item_if.data  <= t;
    @(posedge clk);
    while (!item_if.ready) @(posedge clk);
    ticks_sent++;
    step_align_checker(t);
  endtask

  // period 0: input and output bits are independent random bits
  task automatic run_stream(int n_bits, int period, int lead, int err_pct, int lock_pct);
    logic [31:0] pat;
    in_item_t    t;
    logic        ib;
    logic        ob;
    logic        lk;
    int          skew;
    pat = $urandom;
    for (int k = 0; k < n_bits; k++) begin
      if (period == 0) begin
        ib = 1'($urandom_range(1));
        ob = 1'($urandom_range(1));
      end else begin
        ib = pat[k % period];
        ob = pat[(k + lead) % period];
      end
      if ($urandom_range(99) < err_pct) ob = !ob;
      lk   = ($urandom_range(99) < lock_pct);
      skew = $urandom_range(3);
      repeat ($urandom_range(99) < 20 ? 2 : 1) begin
        t           = random_tick();
        t.in_clock  = 1'b1;
        t.out_clock = 1'b1;
        t.locked    = lk;
        send_tick(t);
      end
      // skew 2: output clock falls a tick late, skew 3: input clock falls late
      t           = random_tick();
      t.locked    = lk;
      t.in_clock  = (skew == 3);
      t.out_clock = (skew == 2);
      if (skew != 3) t.in_bit = ib;
      if (skew != 2) t.out_bit = ob;
      send_tick(t);
      if (skew >= 2) begin
        t           = random_tick();
        t.locked    = lk;
        t.in_clock  = 1'b0;
        t.out_clock = 1'b0;
        if (skew == 3) t.in_bit = ib;
        else t.out_bit = ob;
        send_tick(t);
      end
    end
  endtask

  task automatic test_field_corners();
    logic [TICK_W-1:0] raw;
    for (int k = 31; k >= 8; k--) begin
      raw = TICK_W'(k);
      send_tick(raw);
    end
  endtask

  task automatic test_window_fill();
    run_stream(70, 1, 0, 0, 60);
    run_stream(8, 1, 0, 0, 100);
    run_stream(3, 1, 0, 100, 100);
    run_stream(10, 2, 1, 0, 100);
  endtask

  task automatic test_periodic_patterns();
    int sel;
    int period;
    for (int s = 0; s < 8; s++) begin
      sel    = $urandom_range(6);
      period = (sel == 0) ? 0 : (1 << (sel - 1));
      run_stream($urandom_range(25, 40), period, $urandom_range(31),
                 ($urandom_range(3) == 0) ? 8 : $urandom_range(3), 95);
    end
  endtask

  task automatic test_lock_drops();
    for (int s = 0; s < 3; s++) run_stream(25, 8, $urandom_range(31), 3, $urandom_range(40, 70));
  endtask

  task automatic test_noise();
    repeat (120) send_tick(random_tick());
  endtask

  task automatic test_receiver_hold();
    hold_pending = 1'b1;
    run_stream(40, 4, $urandom_range(31), 2, 100);
  endtask

  task automatic test_no_idle();
    quiet = 1'b1;
    run_stream(25, 16, $urandom_range(31), 2, 100);
    run_stream(25, 32, $urandom_range(31), 0, 100);
    quiet = 1'b0;
  endtask

  // receiver: random stalls, plus one long hold on request
  initial begin
    result_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_pending && !rst) begin
        hold_pending = 1'b0;
        for (int n = 0; n < HOLD_CYCLES; n++) begin
          result_if.ready <= 1'b0;
          @(posedge clk);
        end
      end
      result_if.ready <= quiet || ($urandom_range(99) >= 15);
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    out_item_t got;
    if (!rst && result_if.valid && result_if.ready) begin
      got = result_if.data;
      if (align_results_q.size() == 0) begin
        report_mismatch("result transfer with nothing pending");
      end else begin
        want = align_results_q.pop_front();
        if (got.delay !== want.delay)
          report_mismatch($sformatf("delay %0d, want %0d", got.delay, want.delay));
        if (got.synchronized !== want.synchronized)
          report_mismatch($sformatf("synchronized %b, want %b", got.synchronized,
                                    want.synchronized));
        if (got.error_seen !== want.error_seen)
          report_mismatch($sformatf("error_seen %b, want %b", got.error_seen,
                                    want.error_seen));
        if (got.align_found !== want.align_found)
          report_mismatch($sformatf("align_found %b, want %b", got.align_found,
                                    want.align_found));
      end
    end
  end

  initial begin
    #6_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    rst           <= 1'b1;
    item_if.valid <= 1'b0;
    item_if.data  <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    test_field_corners();
    test_window_fill();
    test_periodic_patterns();
    test_lock_drops();
    test_noise();
    test_receiver_hold();
    test_no_idle();

    item_if.valid <= 1'b0;
    while (align_results_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("tb: covered %0d ticks, %0d alignments found, %0d sync losses",
             ticks_sent, aligns_found, sync_losses);
    $display("tb: streams of period 1 to 32 and random, lock drops, noise, long output hold");
    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
